### rtl/cwps_pkg.sv
// ----------------------------------------------------------------------------
// cwps_pkg
// Shared types, constants and helpers for the window pixel size report parser.
// ----------------------------------------------------------------------------
package cwps_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned SizeW  = 16;
	localparam int unsigned PrefixLen = 4;

	localparam logic [ByteW-1:0] CharEsc   = 8'h1B;
	localparam logic [ByteW-1:0] CharBrack = 8'h5B;
	localparam logic [ByteW-1:0] CharFour  = 8'h34;
	localparam logic [ByteW-1:0] CharSemi  = 8'h3B;
	localparam logic [ByteW-1:0] CharT     = 8'h74;
	localparam logic [ByteW-1:0] CharZero  = 8'h30;
	localparam logic [ByteW-1:0] CharNine  = 8'h39;

	localparam logic [SizeW-1:0] SizeMax = {SizeW{1'b1}};

	// one parsed reply
	typedef struct packed {
		logic             found;
		logic [SizeW-1:0] width_px;
		logic [SizeW-1:0] height_px;
	} res_t;

	// expected byte of the ESC [ 4 ; lead-in at a given position
	function automatic logic [ByteW-1:0] prefix_byte(input logic [1:0] idx);
		logic [ByteW-1:0] b;
		case (idx)
			2'd0:    b = CharEsc;
			2'd1:    b = CharBrack;
			2'd2:    b = CharFour;
			default: b = CharSemi;
		endcase
		return b;
	endfunction

	// acc * 10 + digit, saturated
	function automatic logic [SizeW-1:0] add_digit(input logic [SizeW-1:0] acc,
			input logic [3:0] dig);
		logic [SizeW+3:0] v;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{SizeW{1'b0}}, dig};
		return (v > {4'b0000, SizeMax}) ? SizeMax : v[SizeW-1:0];
	endfunction

endpackage

### rtl/csi_window_pixel_size_parser_core.sv
// ----------------------------------------------------------------------------
// csi_window_pixel_size_parser_core
// Parses an ESC [ 4 ; height ; width t window size reply, one byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries the reply one byte per request in s_tdata, s_tlast marks its
//   final byte. The block looks for the first ESC [ 4 ; and then reads a
//   decimal height, ';', a decimal width and 't' (each saturates at 65535).
//   m_* gives one result per reply, after its last byte: m_tuser is found,
//   m_tdata holds width and height, both zero when nothing valid was parsed.
//   Path: a byte is registered at the input, parsed by the state machine,
//   and the result of a last byte is registered in the result register
//   for m_*. Throughput: one byte per cycle while no last byte waits on a
//   full output register; the parse step between the two is combinational.
//   Reset clears both valid bits and sets the parser to the searching state.
//   When m_tready is low a pending result holds in the output register; the
//   input register keeps taking bytes that cause no result, and only stalls
//   s_tready when a last byte meets a still-full output register.
// ----------------------------------------------------------------------------
module csi_window_pixel_size_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] reply_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] width_px, [31:16] height_px
	output logic        m_tuser    // found
);
	import cwps_pkg::*;

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             last_s1;
	logic             adv_s1;
	logic             out_free;
	res_t             res;
	res_t             res_q;
	logic             m_valid_q;

	// stage 1 moves on unless its result finds the output still full
	assign out_free = !m_valid_q || m_tready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	cwps_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv_s1),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = res_q.found;
	assign m_tdata  = {res_q.height_px, res_q.width_px};

endmodule

### rtl/cwps_parse.sv
// ----------------------------------------------------------------------------
// cwps_parse
// Per-byte parse state machine; gives the result of a reply on its last byte.
// ----------------------------------------------------------------------------
module cwps_parse (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [cwps_pkg::ByteW-1:0] byte_in,
	input  logic                      last_in,
	output cwps_pkg::res_t            res
);
	import cwps_pkg::*;

	typedef enum logic [2:0] {
		PH_P0, PH_P1, PH_P2, PH_P3, PH_HEIGHT, PH_WIDTH, PH_DONE, PH_FAIL
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [SizeW-1:0] height_q, height_d;
	logic [SizeW-1:0] width_q, width_d;
	logic             digit_q, digit_d;
	logic             is_digit;
	logic             is_esc;

	assign is_digit = (byte_in >= CharZero) && (byte_in <= CharNine);
	assign is_esc   = (byte_in == CharEsc);

	// next state for this byte
	always_comb begin
		phase_d  = phase_q;
		height_d = height_q;
		width_d  = width_q;
		digit_d  = digit_q;
		case (phase_q)
			PH_P0, PH_P1, PH_P2, PH_P3: begin
				if (byte_in == prefix_byte(phase_q[1:0])) begin
					case (phase_q)
						PH_P0:   phase_d = PH_P1;
						PH_P1:   phase_d = PH_P2;
						PH_P2:   phase_d = PH_P3;
						default: begin
							phase_d = PH_HEIGHT;
							digit_d = 1'b0;
						end
					endcase
				end else begin
					phase_d = is_esc ? PH_P1 : PH_P0;
				end
			end
			PH_HEIGHT: begin
				if (is_digit) begin
					height_d = add_digit(height_q, byte_in[3:0]);
					digit_d  = 1'b1;
				end else if (byte_in == CharSemi && digit_q) begin
					phase_d = PH_WIDTH;
					digit_d = 1'b0;
				end else begin
					phase_d = PH_FAIL;
				end
			end
			PH_WIDTH: begin
				if (is_digit) begin
					width_d = add_digit(width_q, byte_in[3:0]);
					digit_d = 1'b1;
				end else if (byte_in == CharT && digit_q) begin
					phase_d = PH_DONE;
				end else begin
					phase_d = PH_FAIL;
				end
			end
			default: phase_d = phase_q;
		endcase
	end

	// result as seen after this byte
	always_comb begin
		res.found     = (phase_d == PH_DONE) && (height_d != '0) && (width_d != '0);
		res.width_px  = res.found ? width_d : '0;
		res.height_px = res.found ? height_d : '0;
	end

	// state registers, cleared after the last byte of a reply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_P0;
			height_q <= '0;
			width_q  <= '0;
			digit_q  <= 1'b0;
		end else if (en) begin
			if (last_in) begin
				phase_q  <= PH_P0;
				height_q <= '0;
				width_q  <= '0;
				digit_q  <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				height_q <= height_d;
				width_q  <= width_d;
				digit_q  <= digit_d;
			end
		end
	end

endmodule
